// ===== design/kut_pkg.sv =====
// Shared types, codes and sizes for the keyed session usage table.
package kut_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_END     = 3'd2;
	localparam logic [2:0] OP_LOOKUP  = 3'd3;
	localparam logic [2:0] OP_SUMMARY = 3'd4;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_FOUND     = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_EMPTY     = 3'd6;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] key;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] entry_time;
		logic [31:0] entry_launches;
		logic [31:0] entry_session;
		logic [31:0] total_time;
		logic [31:0] launch_total;
		logic [7:0]  top_key;
		logic [7:0]  recent_key;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0]  key;
		logic [31:0] etime;
		logic [31:0] launches;
		logic [31:0] session;
	} entry_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

endpackage

// ===== design/keyed_session_usage_table.sv =====
// Top level of the keyed session usage table: sequencer, counters and result register.
//
// Request channel (req_valid / req_ready / req): one word carries an operation
// and a key. Tick, session start and the unused codes go from idle straight to
// the finishing step, which loads the output register; the sequencer is then idle
// again and can take the next word. Session end, lookup and summary first walk the
// used entries one per cycle through the single read port of the entry store,
// then finish the same way; with no used entries they skip the walk. For session
// end and lookup an early key match ends the walk.
// A session end that hits or inserts writes its entry back in the finishing step.
// The block takes one request at a time: req_ready is high only while idle.
//
// Response channel (rsp_valid / rsp_ready / rsp): exactly one word per request,
// held in an output register. A new request is taken while an earlier
// response still waits; if the receiver stalls, the sequencer holds in its
// last step until the output register is free.
//
// Reset clears the counters, the fill count and the sequencer. The entry store
// is not cleared: only entries below the fill count are ever read.
module keyed_session_usage_table
	import kut_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	fsm_t state_q, state_d;

	// Architectural state
	logic [CNT_W-1:0] used_q;
	logic [31:0]      time_now_q;
	logic [31:0]      start_time_q;
	logic [31:0]      session_q;

	// Per-request working registers
	logic [2:0]       op_q;
	logic [7:0]       key_q;
	logic [31:0]      elapsed_q;
	logic [CNT_W-1:0] iss_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_ent_q;
	logic [31:0]      sum_time_q;
	logic [31:0]      sum_launch_q;
	logic [31:0]      top_time_q;
	logic [7:0]       top_key_q;
	logic [31:0]      rec_sess_q;
	logic [7:0]       rec_key_q;

	// Read pipeline: index of the entry arriving from the store
	logic             pend_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	// Response register
	logic      rsp_valid_q;
	rsp_word_t rsp_q;

	// Store interface
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic      accept;
	logic      find_op;
	logic      key_match;
	logic      scan_done;
	logic      slot_free;
	logic      fin_fire;
	logic      insert;
	logic      table_full;
	logic      need_scan;
	rsp_word_t res;
	logic [31:0] elapsed_raw;

	kut_entry_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_ready   = (state_q == FSM_IDLE);
	assign accept      = req_valid && req_ready;
	assign find_op     = (op_q == OP_END) || (op_q == OP_LOOKUP);
	assign key_match   = pend_s1 && find_op && (rd_data.key == key_q);
	assign scan_done   = key_match || (!pend_s1 && (iss_q == used_q));
	assign slot_free   = !rsp_valid_q || rsp_ready;
	assign fin_fire    = (state_q == FSM_FINISH) && slot_free;
	assign table_full  = (used_q == CNT_W'(TABLE_DEPTH));
	assign insert      = (op_q == OP_END) && !hit_q && !table_full;
	assign elapsed_raw = time_now_q - start_time_q;
	assign need_scan   = (used_q != '0) && ((req.operation == OP_END) ||
		(req.operation == OP_LOOKUP) || (req.operation == OP_SUMMARY));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = need_scan ? FSM_SCAN : FSM_FINISH;
				end
			end
			FSM_SCAN: begin
				if (scan_done) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (slot_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Store control and response word
	always_comb begin
		rd_en   = (state_q == FSM_SCAN) && (iss_q < used_q) && !key_match;
		rd_addr = iss_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = '{key: key_q, etime: elapsed_q, launches: 32'd1, session: session_q};
		res     = '0;
		res.status = ST_DONE;
		case (op_q)
			OP_END: begin
				if (hit_q) begin
					wr_data.etime    = hit_ent_q.etime + elapsed_q;
					wr_data.launches = hit_ent_q.launches + 32'd1;
					wr_en            = fin_fire;
					res.status       = ST_UPDATED;
				end else if (table_full) begin
					res.status = ST_DROPPED;
				end else begin
					wr_addr    = used_q[IDX_W-1:0];
					wr_en      = fin_fire;
					res.status = ST_INSERTED;
				end
				if (res.status != ST_DROPPED) begin
					res.entry_time     = wr_data.etime;
					res.entry_launches = wr_data.launches;
					res.entry_session  = wr_data.session;
				end
			end
			OP_LOOKUP: begin
				if (hit_q) begin
					res.status         = ST_FOUND;
					res.entry_time     = hit_ent_q.etime;
					res.entry_launches = hit_ent_q.launches;
					res.entry_session  = hit_ent_q.session;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_SUMMARY: begin
				if (used_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					res.total_time   = sum_time_q;
					res.launch_total = sum_launch_q;
					res.top_key      = top_key_q;
					res.recent_key   = rec_key_q;
				end
			end
			default: res.status = ST_DONE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			used_q       <= '0;
			time_now_q   <= '0;
			start_time_q <= '0;
			session_q    <= '0;
			pend_s1      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			iss_q        <= '0;
			hit_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (accept) begin
				iss_q <= '0;
				hit_q <= 1'b0;
				case (req.operation)
					OP_TICK:  time_now_q   <= time_now_q + 32'd1;
					OP_START: start_time_q <= time_now_q;
					OP_END:   session_q    <= session_q + 32'd1;
					default:  ;
				endcase
			end
			if (rd_en) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (key_match) begin
				hit_q <= 1'b1;
			end
			if (fin_fire && insert) begin
				used_q <= used_q + CNT_W'(1);
			end
			// Hold the response until taken; refill from the final step
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.operation;
			key_q        <= req.key;
			elapsed_q    <= (elapsed_raw == '0) ? 32'd1 : elapsed_raw;
			sum_time_q   <= '0;
			sum_launch_q <= '0;
		end
		if (rd_en) begin
			chk_idx_s1 <= iss_q[IDX_W-1:0];
		end
		if (key_match) begin
			hit_idx_q <= chk_idx_s1;
			hit_ent_q <= rd_data;
		end
		// Summary: accumulate and track the first maximum of time and session
		if (pend_s1 && (op_q == OP_SUMMARY)) begin
			sum_time_q   <= sum_time_q + rd_data.etime;
			sum_launch_q <= sum_launch_q + rd_data.launches;
			if ((chk_idx_s1 == '0) || (rd_data.etime > top_time_q)) begin
				top_time_q <= rd_data.etime;
				top_key_q  <= rd_data.key;
			end
			if ((chk_idx_s1 == '0) || (rd_data.session > rec_sess_q)) begin
				rec_sess_q <= rd_data.session;
				rec_key_q  <= rd_data.key;
			end
		end
		if (fin_fire) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/kut_entry_ram.sv =====
// Entry storage: one write port, one registered read port.
module kut_entry_ram
	import kut_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
